### rtl/strided_bitset_next_member_unit_assert.svh
// assertion macros shared by the strided bitset modules
// no dependencies; included by the modules that carry assertions
`ifndef STRIDED_BITSET_NEXT_MEMBER_UNIT_ASSERT_SVH
`define STRIDED_BITSET_NEXT_MEMBER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SBNM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbnm assertion failed");
// next-cycle implication
`define SBNM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbnm assertion failed");
`else
`define SBNM_ASSERT_IMP(name, clk, rst, ante, cons)
`define SBNM_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### rtl/sbnm_pkg.sv
// shared constants, codes and types for the strided bitset unit
// no dependencies
package sbnm_pkg;

   // set geometry
   localparam int SetBits = 64;
   localparam int IdxW    = $clog2(SetBits);
   localparam int CntW    = $clog2(SetBits + 1);
   localparam int ValW    = 8;
   localparam int OutCntW = 7;
   localparam int CsrIdxW = 1;

   // item kinds
   localparam logic [1:0] KindClear = 2'd0;
   localparam logic [1:0] KindAdd   = 2'd1;
   localparam logic [1:0] KindQuery = 2'd2;

   // result status
   localparam logic StatusOk  = 1'b0;
   localparam logic StatusBad = 1'b1;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegLowest  = 1'd0;
   localparam logic [CsrIdxW-1:0] RegHighest = 1'd1;

   // derived configuration view
   typedef struct packed {
      logic [ValW-1:0] lowest;
      logic [ValW-1:0] top;
      logic [CntW-1:0] span;
      logic            ok;
   } cfg_info_type;

   // bitset update command
   typedef struct packed {
      logic            clear;
      logic            set;
      logic [IdxW-1:0] idx;
   } set_cmd_type;

endpackage

### rtl/sbnm_csr.sv
// configuration registers and derived range limits
// depends on sbnm_pkg
module sbnm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [sbnm_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [sbnm_pkg::ValW-1:0]      csr_wdata,
   output sbnm_pkg::cfg_info_type         cfg,
   output logic                           cfg_clear
);

   logic [sbnm_pkg::ValW-1:0] lowest_ff, lowest_in;
   logic [sbnm_pkg::ValW-1:0] highest_ff, highest_in;
   logic [sbnm_pkg::ValW:0]   limit;
   logic [sbnm_pkg::ValW-1:0] top;
   logic [sbnm_pkg::ValW-1:0] span_raw;

   // register writes
   always_comb begin
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      cfg_clear  = 1'b0;
      if (csr_write) begin
         case (csr_index)
            sbnm_pkg::RegLowest: begin
               lowest_in = csr_wdata;
               cfg_clear = 1'b1;
            end
            sbnm_pkg::RegHighest: begin
               highest_in = csr_wdata;
               cfg_clear  = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff  <= '0;
         highest_ff <= 8'd59;
      end else begin
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
      end
   end

   // usable top clipped to the set size
   assign limit    = {1'b0, lowest_ff} + (sbnm_pkg::ValW + 1)'(sbnm_pkg::SetBits - 1);
   assign top      = ({1'b0, highest_ff} < limit) ? highest_ff
                                                  : limit[sbnm_pkg::ValW-1:0];
   assign span_raw = top - lowest_ff + 8'd1;

   assign cfg.lowest = lowest_ff;
   assign cfg.top    = top;
   assign cfg.span   = (highest_ff >= lowest_ff) ? span_raw[sbnm_pkg::CntW-1:0] : '0;
   assign cfg.ok     = (highest_ff >= lowest_ff);

endmodule

### rtl/sbnm_bitset.sv
// membership bits with running population count
// depends on sbnm_pkg and the assertion header
`include "strided_bitset_next_member_unit_assert.svh"
module sbnm_bitset (
   input  logic                          clock,
   input  logic                          reset,
   input  sbnm_pkg::set_cmd_type         cmd,
   input  logic [sbnm_pkg::IdxW-1:0]     rd_idx,
   output logic                          rd_bit,
   output logic [sbnm_pkg::CntW-1:0]     population
);

   logic [sbnm_pkg::SetBits-1:0] member_ff, member_in;
   logic [sbnm_pkg::CntW-1:0]    pop_ff, pop_in;

   // clear wins over set; population counts only fresh bits
   always_comb begin
      member_in = member_ff;
      pop_in    = pop_ff;
      if (cmd.clear) begin
         member_in = '0;
         pop_in    = '0;
      end else if (cmd.set && !member_ff[cmd.idx]) begin
         member_in[cmd.idx] = 1'b1;
         pop_in             = pop_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff <= '0;
         pop_ff    <= '0;
      end else begin
         member_ff <= member_in;
         pop_ff    <= pop_in;
      end
   end

   assign rd_bit     = member_ff[rd_idx];
   assign population = pop_ff;

   // checks
   `SBNM_ASSERT_NXT(a_clear_empties, clock, reset, cmd.clear, pop_ff == '0 && member_ff == '0)
   `SBNM_ASSERT_IMP(a_pop_bounded, clock, reset, 1'b1, pop_ff <= sbnm_pkg::CntW'(sbnm_pkg::SetBits))

endmodule

### rtl/sbnm_seq.sv
// item sequencer with one shared adder for range walk and member scan
// depends on sbnm_pkg and the assertion header
`include "strided_bitset_next_member_unit_assert.svh"
module sbnm_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [sbnm_pkg::ValW-1:0]     req_range_low,
   input  logic [sbnm_pkg::ValW-1:0]     req_range_high,
   input  logic [sbnm_pkg::ValW-1:0]     req_stride,
   input  logic [sbnm_pkg::ValW-1:0]     req_probe_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic                          rsp_is_member,
   output logic [sbnm_pkg::OutCntW-1:0]  rsp_distance_next,
   output logic [sbnm_pkg::OutCntW-1:0]  rsp_population,
   input  sbnm_pkg::cfg_info_type        cfg,
   input  logic                          rd_bit,
   input  logic [sbnm_pkg::CntW-1:0]     population,
   output sbnm_pkg::set_cmd_type         cmd,
   output logic [sbnm_pkg::IdxW-1:0]     rd_idx
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StCheck = 3'd1;
   localparam logic [2:0] StAdd   = 3'd2;
   localparam logic [2:0] StScan  = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [1:0]                    kind_ff, kind_in;
   logic [sbnm_pkg::ValW-1:0]     lo_ff, lo_in;
   logic [sbnm_pkg::ValW-1:0]     hi_ff, hi_in;
   logic [sbnm_pkg::ValW-1:0]     stride_ff, stride_in;
   logic [sbnm_pkg::ValW-1:0]     probe_ff, probe_in;
   logic [sbnm_pkg::ValW:0]       walk_ff, walk_in;
   logic [sbnm_pkg::IdxW-1:0]     scan_idx_ff, scan_idx_in;
   logic [sbnm_pkg::CntW-1:0]     scan_dist_ff, scan_dist_in;
   logic                          res_status_ff, res_status_in;
   logic                          res_member_ff, res_member_in;
   logic [sbnm_pkg::CntW-1:0]     res_dist_ff, res_dist_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic                          rsp_member_ff, rsp_member_in;
   logic [sbnm_pkg::OutCntW-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [sbnm_pkg::OutCntW-1:0]  rsp_pop_ff, rsp_pop_in;

   logic [sbnm_pkg::ValW-1:0]     probe_off;
   logic [sbnm_pkg::IdxW-1:0]     off;
   logic [sbnm_pkg::ValW:0]       walk_off;
   logic [sbnm_pkg::IdxW-1:0]     add_idx;
   logic                          add_bad;
   logic                          query_bad;
   logic [sbnm_pkg::ValW:0]       add_a;
   logic [sbnm_pkg::ValW:0]       add_b;
   logic [sbnm_pkg::ValW:0]       add_sum;
   logic                          at_last;
   logic [sbnm_pkg::IdxW-1:0]     idx_next;

   // offsets into the bitset
   assign probe_off = probe_ff - cfg.lowest;
   assign off       = probe_off[sbnm_pkg::IdxW-1:0];
   assign walk_off  = walk_ff - {1'b0, cfg.lowest};
   assign add_idx   = walk_off[sbnm_pkg::IdxW-1:0];

   // argument checks
   assign add_bad   = !cfg.ok || (lo_ff > hi_ff) || (stride_ff == '0)
                      || (lo_ff < cfg.lowest) || (hi_ff > cfg.top);
   assign query_bad = !cfg.ok || (probe_ff < cfg.lowest) || (probe_ff > cfg.top);

   // shared adder: stride step while adding, index step while checking and scanning
   always_comb begin
      case (state_ff)
         StAdd: begin
            add_a = walk_ff;
            add_b = {1'b0, stride_ff};
         end
         StCheck: begin
            add_a = (sbnm_pkg::ValW + 1)'(off);
            add_b = (sbnm_pkg::ValW + 1)'(1);
         end
         default: begin
            add_a = (sbnm_pkg::ValW + 1)'(scan_idx_ff);
            add_b = (sbnm_pkg::ValW + 1)'(1);
         end
      endcase
   end

   assign add_sum  = add_a + add_b;
   assign at_last  = (add_a == (sbnm_pkg::ValW + 1)'(cfg.span - 1'b1));
   assign idx_next = at_last ? '0 : add_sum[sbnm_pkg::IdxW-1:0];

   assign rd_idx = (state_ff == StCheck) ? off : scan_idx_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      stride_in     = stride_ff;
      probe_in      = probe_ff;
      walk_in       = walk_ff;
      scan_idx_in   = scan_idx_ff;
      scan_dist_in  = scan_dist_ff;
      res_status_in = res_status_ff;
      res_member_in = res_member_ff;
      res_dist_in   = res_dist_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_member_in = rsp_member_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_pop_in    = rsp_pop_ff;
      cmd           = '0;

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               kind_in   = req_kind;
               lo_in     = req_range_low;
               hi_in     = req_range_high;
               stride_in = req_stride;
               probe_in  = req_probe_value;
               state_in  = StCheck;
            end
         end
         StCheck: begin
            res_status_in = sbnm_pkg::StatusOk;
            res_member_in = 1'b0;
            res_dist_in   = '0;
            state_in      = StDone;
            case (kind_ff)
               sbnm_pkg::KindClear: begin
                  cmd.clear = 1'b1;
               end
               sbnm_pkg::KindAdd: begin
                  if (add_bad) begin
                     res_status_in = sbnm_pkg::StatusBad;
                  end else begin
                     walk_in  = {1'b0, lo_ff};
                     state_in = StAdd;
                  end
               end
               sbnm_pkg::KindQuery: begin
                  if (query_bad) begin
                     res_status_in = sbnm_pkg::StatusBad;
                  end else begin
                     res_member_in = rd_bit;
                     if (population != '0) begin
                        scan_idx_in  = idx_next;
                        scan_dist_in = sbnm_pkg::CntW'(1);
                        state_in     = StScan;
                     end
                  end
               end
               default: begin
                  res_status_in = sbnm_pkg::StatusBad;
               end
            endcase
         end
         StAdd: begin
            if (walk_ff <= {1'b0, hi_ff}) begin
               cmd.set = 1'b1;
               cmd.idx = add_idx;
               walk_in = add_sum;
            end else begin
               state_in = StDone;
            end
         end
         StScan: begin
            if (rd_bit) begin
               res_dist_in = scan_dist_ff;
               state_in    = StDone;
            end else begin
               scan_idx_in  = idx_next;
               scan_dist_in = scan_dist_ff + 1'b1;
            end
         end
         StDone: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_member_in = res_member_ff;
               rsp_dist_in   = sbnm_pkg::OutCntW'(res_dist_ff);
               rsp_pop_in    = sbnm_pkg::OutCntW'(population);
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      stride_ff     <= stride_in;
      probe_ff      <= probe_in;
      walk_ff       <= walk_in;
      scan_idx_ff   <= scan_idx_in;
      scan_dist_ff  <= scan_dist_in;
      res_status_ff <= res_status_in;
      res_member_ff <= res_member_in;
      res_dist_ff   <= res_dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_member_ff <= rsp_member_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pop_ff    <= rsp_pop_in;
   end

   assign req_stall         = (state_ff != StIdle);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_member     = rsp_member_ff;
   assign rsp_distance_next = rsp_dist_ff;
   assign rsp_population    = rsp_pop_ff;

   // checks
   `SBNM_ASSERT_NXT(a_accept_to_check, clock, reset, req_valid && !req_stall, state_ff == StCheck)
   `SBNM_ASSERT_IMP(a_scan_nonempty, clock, reset, state_ff == StScan, population != '0)
   `SBNM_ASSERT_IMP(a_scan_within_span, clock, reset, state_ff == StScan, scan_dist_ff <= cfg.span)

endmodule

### rtl/strided_bitset_next_member_unit.sv
// Strided membership set over lowest_value..highest_value (at most 64 values),
// one item at a time. A clear or error item goes from acceptance through a
// check state to a done state, which loads its result into the output register
// once the output is free; a query on a non-empty set scans bit positions until
// it reaches the next member (up to the span, 64 at most); a strided add walks
// the range after the check, setting one value per step (up to 64). The
// range walk and the member scan each advance one position a cycle through one
// shared adder. The input stalls until the item's result has been loaded into
// the output register. Writing either register empties the set.
// depends on sbnm_pkg, sbnm_csr, sbnm_bitset and sbnm_seq
module strided_bitset_next_member_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [sbnm_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sbnm_pkg::ValW-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [sbnm_pkg::ValW-1:0]     req_range_low,
   input  logic [sbnm_pkg::ValW-1:0]     req_range_high,
   input  logic [sbnm_pkg::ValW-1:0]     req_stride,
   input  logic [sbnm_pkg::ValW-1:0]     req_probe_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic                          rsp_is_member,
   output logic [sbnm_pkg::OutCntW-1:0]  rsp_distance_next,
   output logic [sbnm_pkg::OutCntW-1:0]  rsp_population
);

   sbnm_pkg::cfg_info_type        cfg;
   logic                          cfg_clear;
   sbnm_pkg::set_cmd_type         seq_cmd;
   sbnm_pkg::set_cmd_type         set_cmd;
   logic [sbnm_pkg::IdxW-1:0]     rd_idx;
   logic                          rd_bit;
   logic [sbnm_pkg::CntW-1:0]     population;

   // configuration registers
   sbnm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_clear (cfg_clear)
   );

   // a register write also empties the set
   always_comb begin
      set_cmd       = seq_cmd;
      set_cmd.clear = seq_cmd.clear | cfg_clear;
   end

   sbnm_bitset u_bitset (
      .clock      (clock),
      .reset      (reset),
      .cmd        (set_cmd),
      .rd_idx     (rd_idx),
      .rd_bit     (rd_bit),
      .population (population)
   );

   sbnm_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_stride        (req_stride),
      .req_probe_value   (req_probe_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_is_member     (rsp_is_member),
      .rsp_distance_next (rsp_distance_next),
      .rsp_population    (rsp_population),
      .cfg               (cfg),
      .rd_bit            (rd_bit),
      .population        (population),
      .cmd               (seq_cmd),
      .rd_idx            (rd_idx)
   );

endmodule
